// ----- src/rpsc_pkg.sv -----
//------------------------------------------------------------------------------
// rpsc_pkg
// Shared types and constants of the RGB pixel to SPI code word encoder.
//------------------------------------------------------------------------------
package rpsc_pkg;

	localparam int unsigned PIXEL_W       = 24;
	localparam int unsigned CODE_W        = 16;
	localparam int unsigned PAD_W         = 6;
	localparam int unsigned BIT_CNT_W     = 5;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned QUEUE_DEPTH   = 2;

	localparam logic [CODE_W-1:0]    ZERO_CODE_RST = 16'h7000;
	localparam logic [CODE_W-1:0]    ONE_CODE_RST  = 16'hFF00;
	localparam logic [PAD_W-1:0]     PAD_COUNT_RST = 6'd20;
	localparam logic [PAD_W-1:0]     PAD_COUNT_MAX = 6'd40;
	localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX  = 5'd23;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ZERO_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ONE_CODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAD_COUNT = 2'd2;

	typedef struct packed {
		logic [PIXEL_W-1:0] grb;
		logic [PAD_W-1:0]   pad;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0] zero_code;
		logic [CODE_W-1:0] one_code;
		logic [PAD_W-1:0]  pad_count;
	} cfg_t;

endpackage

// ----- src/rpsc_front.sv -----
//------------------------------------------------------------------------------
// rpsc_front
// Accepts pixels, reorders them to green-red-blue and sizes the reset padding.
//------------------------------------------------------------------------------
module rpsc_front (
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [rpsc_pkg::PIXEL_W-1:0] s_axis_tdata,  // pixel_color
	input  logic                        s_axis_tlast,  // last_pixel
	input  logic [rpsc_pkg::PAD_W-1:0]   pad_count,
	input  logic                        q_full,
	output logic                        q_wr,
	output rpsc_pkg::item_t             q_wr_item
);
	import rpsc_pkg::*;

	logic [PAD_W-1:0] pad_sat;

	always_comb begin
		if (pad_count > PAD_COUNT_MAX) begin
			pad_sat = PAD_COUNT_MAX;
		end else begin
			pad_sat = pad_count;
		end
	end

	assign s_axis_tready  = !q_full;
	assign q_wr           = s_axis_tvalid && !q_full;
	assign q_wr_item.grb  = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[7:0]};
	assign q_wr_item.pad  = s_axis_tlast ? pad_sat : '0;

endmodule

// ----- src/rpsc_queue.sv -----
//------------------------------------------------------------------------------
// rpsc_queue
// Short first-in first-out queue of classified pixels between front and back.
//------------------------------------------------------------------------------
module rpsc_queue #(
	parameter int unsigned Depth = rpsc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  rpsc_pkg::item_t wr_item,
	output logic            full,
	input  logic            rd,
	output logic            rd_valid,
	output rpsc_pkg::item_t rd_item
);
	import rpsc_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	item_t            mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CntW'(Depth));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr && !full;
	assign do_rd    = rd && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/rpsc_back.sv -----
//------------------------------------------------------------------------------
// rpsc_back
// Serializes one pixel into bit code words, then the zero reset words.
//------------------------------------------------------------------------------
module rpsc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rpsc_pkg::cfg_t              cfg,
	input  logic                        q_valid,
	input  rpsc_pkg::item_t             q_item,
	output logic                        q_rd,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [rpsc_pkg::CODE_W-1:0] m_axis_tdata,  // code_word
	output logic                        m_axis_tlast   // run_end
);
	import rpsc_pkg::*;

	logic                 busy_q;
	logic                 in_pad_q;
	logic [PIXEL_W-1:0]   grb_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [PAD_W-1:0]     pad_q;
	logic                 tvalid_q;
	logic [CODE_W-1:0]    tdata_q;
	logic                 tlast_q;

	logic                 out_free;
	logic                 emit;
	logic [CODE_W-1:0]    word;
	logic                 word_last;
	logic                 load;

	assign out_free = !tvalid_q || m_axis_tready;
	assign emit     = busy_q && out_free;

	always_comb begin
		if (in_pad_q) begin
			word      = '0;
			word_last = (pad_q == PAD_W'(1));
		end else begin
			word      = grb_q[PIXEL_W-1] ? cfg.one_code : cfg.zero_code;
			word_last = (bit_cnt_q == LAST_BIT_IDX) && (pad_q == '0);
		end
	end

	assign load = q_valid && (!busy_q || (emit && word_last));
	assign q_rd = load;

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			in_pad_q  <= 1'b0;
			bit_cnt_q <= '0;
			pad_q     <= '0;
			grb_q     <= '0;
			tvalid_q  <= 1'b0;
			tdata_q   <= '0;
			tlast_q   <= 1'b0;
		end else begin
			if (emit) begin
				tvalid_q <= 1'b1;
				tdata_q  <= word;
				tlast_q  <= word_last;
			end else if (m_axis_tready) begin
				tvalid_q <= 1'b0;
			end

			if (load) begin
				busy_q    <= 1'b1;
				in_pad_q  <= 1'b0;
				bit_cnt_q <= '0;
				grb_q     <= q_item.grb;
				pad_q     <= q_item.pad;
			end else if (emit) begin
				if (word_last) begin
					busy_q <= 1'b0;
				end
				if (in_pad_q) begin
					pad_q <= pad_q - 1'b1;
				end else begin
					grb_q     <= {grb_q[PIXEL_W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == LAST_BIT_IDX) begin
						in_pad_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ----- src/rgb_pixel_spi_code_encoder.sv -----
//------------------------------------------------------------------------------
// rgb_pixel_spi_code_encoder
// Turns RGB pixels into 16-bit SPI code words for a serial LED chain.
//------------------------------------------------------------------------------
// Each transfer on the s_axis channel carries one pixel; tlast marks the last
// pixel of a frame. The block sends 24 code words per pixel on m_axis, green
// byte first, then red, then blue, each most significant bit first. A one bit
// becomes one_code and a zero bit zero_code. After a last pixel, the number of
// zero words held in the reset count register follows, saturated at 40.
// m_axis tlast is high on the final word caused by each pixel.
// When the block is empty, a pixel passes through the queue and the serializer
// before its first word is presented on m_axis from the output register. The
// serializer sends one word per cycle while the receiver takes them, and takes
// the next pixel from a two-entry queue while sending the final word of the
// previous one, so a new pixel is taken before the last one is done.
// When the receiver stalls, the output register holds its word, the queue
// fills and s_axis tready drops. Reset empties the queue and the serializer
// and restores the register defaults. The user writes the registers on the
// always-ready cfg channel only while the block is idle; no logic checks it.
//------------------------------------------------------------------------------
module rgb_pixel_spi_code_encoder #(
	parameter int unsigned QUEUE_DEPTH = rpsc_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [rpsc_pkg::PIXEL_W-1:0]   s_axis_tdata,  // pixel_color
	input  logic                          s_axis_tlast,  // last_pixel
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rpsc_pkg::CODE_W-1:0]    m_axis_tdata,  // code_word
	output logic                          m_axis_tlast,  // run_end
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rpsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpsc_pkg::CODE_W-1:0]    cfg_data
);
	import rpsc_pkg::*;

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_wr;
	item_t q_wr_item;
	logic  q_rd;
	logic  q_valid;
	item_t q_rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_code <= ZERO_CODE_RST;
			cfg_q.one_code  <= ONE_CODE_RST;
			cfg_q.pad_count <= PAD_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IDX_ZERO_CODE: cfg_q.zero_code <= cfg_data;
				CFG_IDX_ONE_CODE:  cfg_q.one_code  <= cfg_data;
				CFG_IDX_PAD_COUNT: cfg_q.pad_count <= cfg_data[PAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rpsc_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.pad_count     (cfg_q.pad_count),
		.q_full        (q_full),
		.q_wr          (q_wr),
		.q_wr_item     (q_wr_item)
	);

	rpsc_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_item  (q_wr_item),
		.full     (q_full),
		.rd       (q_rd),
		.rd_valid (q_valid),
		.rd_item  (q_rd_item)
	);

	rpsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (q_rd_item),
		.q_rd          (q_rd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the RGB pixel to SPI code word encoder.
//------------------------------------------------------------------------------
// Pixels go in on s_axis and code words come out on m_axis. Each accepted
// pixel is expanded here into the words it should produce, using a local copy
// of the three registers, and every word that leaves the block is checked
// against the oldest expected word. A short table of directed pixels and
// register writes comes first, followed by random frames in several register
// settings. Both sides insert random gaps, and the receiver holds off once for
// a long stretch so that the input queue fills and the block stalls.
//------------------------------------------------------------------------------
module tb_top;

	import rpsc_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 500000;
	localparam int unsigned RAND_PHASES    = 8;
	localparam int unsigned PHASE_PIXELS   = 40;
	localparam int unsigned HOLD_CYCLES    = 500;
	localparam int unsigned DRAIN_CYCLES   = 40;
	localparam int unsigned DIR_ROWS       = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		ROW_PIXEL,
		ROW_PIXEL_FIXED,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   index;
		logic [PIXEL_W-1:0]     value;
		logic                   last;
		logic [CODE_W-1:0]      fixed_word;
		int                     fixed_pad;
	} stim_row_t;

	typedef struct {
		logic [CODE_W-1:0] code_word;
		logic              run_end;
	} spi_word_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_valid = 1'b0;
	logic                 s_ready;
	logic [PIXEL_W-1:0]   s_data = '0;
	logic                 s_last = 1'b0;
	logic                 m_valid;
	logic                 m_ready = 1'b0;
	logic [CODE_W-1:0]    m_data;
	logic                 m_last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CODE_W-1:0]    cfg_data = '0;

	logic [CODE_W-1:0]    zero_code_sh;
	logic [CODE_W-1:0]    one_code_sh;
	logic [PAD_W-1:0]     pad_count_sh;

	spi_word_t            pending_words [$];
	stim_row_t            directed_rows [DIR_ROWS];
	int                   mismatches = 0;
	int unsigned          cycles = 0;
	bit                   hold_request = 1'b0;

	rgb_pixel_spi_code_encoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata (s_data),
		.s_axis_tlast (s_last),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata (m_data),
		.m_axis_tlast (m_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("FAIL rgb_pixel_spi_code_encoder");
				$finish;
			end
		end
	end

	function automatic void add_word(logic [CODE_W-1:0] word, logic run_end);
		spi_word_t w;
		w.code_word = word;
		w.run_end   = run_end;
		pending_words.push_back(w);
	endfunction

	// Words go out green, red, blue, each byte MSB first.
	function automatic void encode_pixel(logic [PIXEL_W-1:0] color, logic last);
		logic [PIXEL_W-1:0] grb;
		int                 pad;
		int                 total;
		grb   = {color[15:8], color[23:16], color[7:0]};
		pad   = 0;
		if (last) begin
			pad = (pad_count_sh > PAD_COUNT_MAX) ? int'(PAD_COUNT_MAX) : int'(pad_count_sh);
		end
		total = PIXEL_W + pad;
		for (int k = 0; k < PIXEL_W; k++) begin
			add_word(grb[PIXEL_W-1-k] ? one_code_sh : zero_code_sh, k == total - 1);
		end
		for (int k = PIXEL_W; k < total; k++) begin
			add_word('0, k == total - 1);
		end
	endfunction

	function automatic void add_fixed_words(logic [CODE_W-1:0] word, int pad);
		for (int k = 0; k < PIXEL_W + pad; k++) begin
			add_word((k < PIXEL_W) ? word : '0, k == PIXEL_W + pad - 1);
		end
	endfunction

	function automatic int pick_gap(bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 70) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CODE_W'($urandom);
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] pick_pad();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'(PAD_COUNT_MAX);
			2: return 16'd63;
			3: return 16'($urandom_range(41, 63));
			default: return 16'($urandom_range(0, 12)) | (16'($urandom) & 16'hFFC0);
		endcase
	endfunction

	function automatic logic [PIXEL_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return PIXEL_W'(8'hFF) << (8 * $urandom_range(0, 2));
			default: return PIXEL_W'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		s_valid   <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that back-to-back writes follow without a gap.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CODE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_IDX_ZERO_CODE: zero_code_sh = data;
			CFG_IDX_ONE_CODE:  one_code_sh  = data;
			CFG_IDX_PAD_COUNT: pad_count_sh = data[PAD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_pixel(logic [PIXEL_W-1:0] color, logic last, int gap,
	                          bit fixed, logic [CODE_W-1:0] fixed_word, int fixed_pad);
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= color;
		s_last  <= last;
		do @(posedge clk); while (!s_ready);
		if (fixed) begin
			add_fixed_words(fixed_word, fixed_pad);
		end else begin
			encode_pixel(color, last);
		end
	endtask

	// Receiver: checks each word transfer and drives tready with random stalls.
	initial begin
		spi_word_t   exp_w;
		int          stall_left;
		int          mode_timer;
		int          r;
		bit          busy_mode;
		bit          hold_done;
		stall_left = 0;
		mode_timer = 0;
		busy_mode  = 1'b0;
		hold_done  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (m_valid && m_ready) begin
					if (pending_words.size() == 0) begin
						$display("%0t: unexpected word transfer, expected none, got %h/%b",
						         $time, m_data, m_last);
						mismatches++;
					end else begin
						exp_w = pending_words.pop_front();
						if (m_data !== exp_w.code_word) begin
							$display("%0t: code_word mismatch, expected %h, got %h",
							         $time, exp_w.code_word, m_data);
							mismatches++;
						end
						if (m_last !== exp_w.run_end) begin
							$display("%0t: run_end mismatch, expected %b, got %b",
							         $time, exp_w.run_end, m_last);
							mismatches++;
						end
					end
				end
				if (hold_request && !hold_done) begin
					hold_done  = 1'b1;
					stall_left = HOLD_CYCLES;
				end
				if (mode_timer == 0) begin
					mode_timer = $urandom_range(100, 400);
					busy_mode  = ($urandom_range(0, 2) != 0);
				end
				mode_timer--;
				if (stall_left == 0 && busy_mode) begin
					r = $urandom_range(0, 99);
					if (r < 3) begin
						stall_left = $urandom_range(15, 60);
					end else if (r < 30) begin
						stall_left = $urandom_range(1, 3);
					end
				end
				if (stall_left > 0) begin
					stall_left--;
					m_ready <= 1'b0;
				end else begin
					m_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		stim_row_t row;
		int        n;
		int        flen;
		bit        burst;
		logic      last;

		directed_rows = '{
			'{ROW_PIXEL_FIXED, CFG_IDX_ZERO_CODE, 24'h000000, 1'b0, 16'h7000, 0},
			'{ROW_PIXEL_FIXED, CFG_IDX_ZERO_CODE, 24'hFFFFFF, 1'b0, 16'hFF00, 0},
			'{ROW_PIXEL_FIXED, CFG_IDX_ZERO_CODE, 24'h000000, 1'b1, 16'h7000, 20},
			'{ROW_PIXEL,       CFG_IDX_ZERO_CODE, 24'h800000, 1'b0, 16'h0000, 0},
			'{ROW_PIXEL,       CFG_IDX_ZERO_CODE, 24'h008000, 1'b0, 16'h0000, 0},
			'{ROW_PIXEL,       CFG_IDX_ZERO_CODE, 24'h000001, 1'b0, 16'h0000, 0},
			'{ROW_PIXEL,       CFG_IDX_ZERO_CODE, 24'h123456, 1'b1, 16'h0000, 0},
			'{ROW_CFG,         CFG_IDX_ZERO_CODE, 24'h000000, 1'b0, 16'h0000, 0},
			'{ROW_CFG,         CFG_IDX_ONE_CODE,  24'h00FFFF, 1'b0, 16'h0000, 0},
			'{ROW_CFG,         CFG_IDX_PAD_COUNT, 24'h000000, 1'b0, 16'h0000, 0},
			'{ROW_PIXEL_FIXED, CFG_IDX_ZERO_CODE, 24'hFFFFFF, 1'b1, 16'hFFFF, 0},
			'{ROW_PIXEL_FIXED, CFG_IDX_ZERO_CODE, 24'h000000, 1'b1, 16'h0000, 0},
			'{ROW_CFG,         CFG_IDX_PAD_COUNT, 24'h00003F, 1'b0, 16'h0000, 0},
			'{ROW_PIXEL_FIXED, CFG_IDX_ZERO_CODE, 24'hFFFFFF, 1'b1, 16'hFFFF, 40},
			'{ROW_CFG,         CFG_IDX_UNUSED,    24'h000005, 1'b0, 16'h0000, 0},
			'{ROW_PIXEL_FIXED, CFG_IDX_ZERO_CODE, 24'h000000, 1'b1, 16'h0000, 40},
			'{ROW_CFG,         CFG_IDX_ZERO_CODE, 24'h00A5A5, 1'b0, 16'h0000, 0},
			'{ROW_CFG,         CFG_IDX_ONE_CODE,  24'h005A5A, 1'b0, 16'h0000, 0},
			'{ROW_CFG,         CFG_IDX_PAD_COUNT, 24'h000001, 1'b0, 16'h0000, 0},
			'{ROW_PIXEL,       CFG_IDX_ZERO_CODE, 24'hC33C5A, 1'b1, 16'h0000, 0},
			'{ROW_PIXEL,       CFG_IDX_ZERO_CODE, 24'h0F0F0F, 1'b0, 16'h0000, 0},
			'{ROW_CFG,         CFG_IDX_PAD_COUNT, 24'h000028, 1'b0, 16'h0000, 0},
			'{ROW_PIXEL,       CFG_IDX_ZERO_CODE, 24'hF0F0F0, 1'b1, 16'h0000, 0}
		};

		zero_code_sh = ZERO_CODE_RST;
		one_code_sh  = ONE_CODE_RST;
		pad_count_sh = PAD_COUNT_RST;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				cfg_write(row.index, row.value[CODE_W-1:0]);
			end else begin
				push_pixel(row.value, row.last, pick_gap(1'b0),
				           row.kind == ROW_PIXEL_FIXED, row.fixed_word, row.fixed_pad);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			cfg_write(CFG_IDX_ZERO_CODE, pick_code());
			cfg_write(CFG_IDX_ONE_CODE, pick_code());
			if ($urandom_range(0, 3) == 0) begin
				cfg_write(CFG_IDX_UNUSED, CODE_W'($urandom));
			end
			cfg_write(CFG_IDX_PAD_COUNT, pick_pad());
			burst = ($urandom_range(0, 3) == 0);
			n = 0;
			while (n < PHASE_PIXELS) begin
				flen = $urandom_range(1, 12);
				for (int j = 0; j < flen && n < PHASE_PIXELS; j++) begin
					last = (j == flen - 1);
					if ($urandom_range(0, 5) == 0) begin
						last = 1'($urandom);
					end
					push_pixel(pick_pixel(), last, pick_gap(burst), 1'b0, '0, 0);
					n++;
					if (ph == 2 && n == 5) begin
						hold_request = 1'b1;
					end
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS rgb_pixel_spi_code_encoder");
		end else begin
			$display("FAIL rgb_pixel_spi_code_encoder");
		end
		$finish;
	end

endmodule
